// ----- hdl/frsq_pkg.sv -----
// ---------------------------------------------------------------------------
// frsq_pkg: shared types, constants and functions for the fair-share run queue
// Holds the queue entry record, request and status codes, the controller
// states and the nice-to-weight table.
// ---------------------------------------------------------------------------
package frsq_pkg;

   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int WEIGHT_MAX      = 88761;
   localparam int WEIGHT_W        = 17;
   localparam int VT_W            = 31;
   localparam int TID_W           = 16;
   localparam int STAMP_W         = 32;
   localparam int TICK_W          = 16;
   localparam int GRAN_W          = 10;
   localparam int LAT_W           = 16;
   localparam int NICE_W          = 6;
   localparam int NICE_SHIFT      = 10;   // charge scale is 1024
   localparam int NICE_OFFSET     = 20;
   localparam int NICE_LEVELS     = 40;
   localparam int GRAN_RESET      = 40;
   localparam int LAT_RESET       = 40 * 8;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_POP    = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_NONE   = 2'd3
   } req_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CSR_GRAN = 1'b0,
      CSR_LAT  = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHARGE,
      ST_MULT,
      ST_SLICE,
      ST_SEND
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   // one queued task; the chain keeps these sorted by (vtime, stamp)
   typedef struct packed {
      logic [VT_W-1:0]     vtime;
      logic [STAMP_W-1:0]  stamp;
      logic [TID_W-1:0]    task_id;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   // load weight for a clamped nice index (0 means nice -20)
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [5:0] idx);
      logic [WEIGHT_W-1:0] w;
      case (idx)
         6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
         6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
         6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
         6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
         6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
         6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
         6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
         6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
         6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
         6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
         6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
         6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
         6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
         default: w = 17'd15;
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/frsq_cell.sv -----
// ---------------------------------------------------------------------------
// frsq_cell: one cell of the sorted run-queue chain
// Holds one entry. On insert it keeps, takes the new entry or takes its left
// neighbor's entry; on pop it takes its right neighbor's entry.
// ---------------------------------------------------------------------------
module frsq_cell
   import frsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   new_ent,
   input  logic        left_valid,
   input  entry_type   left_ent,
   input  logic        left_gt,
   input  logic        right_valid,
   input  entry_type   right_ent,
   output logic        gt,
   output logic        valid,
   output entry_type   ent
);

   logic      valid_ff, valid_in;
   entry_type ent_ff, ent_in;

   // new entry sorts ahead of this one (empty cells always give way)
   assign gt = !valid_ff ||
               ({new_ent.vtime, new_ent.stamp} < {ent_ff.vtime, ent_ff.stamp});

   always_comb begin
      valid_in = valid_ff;
      ent_in   = ent_ff;
      case (op)
         CELL_INSERT: begin
            if (gt) begin
               valid_in = left_gt ? left_valid : 1'b1;
               ent_in   = left_gt ? left_ent : new_ent;
            end
         end
         CELL_POP: begin
            valid_in = right_valid;
            ent_in   = right_ent;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign valid = valid_ff;
   assign ent   = ent_ff;

endmodule

// ----- hdl/frsq_div.sv -----
// ---------------------------------------------------------------------------
// frsq_div: restoring divider, one quotient bit per cycle
// done pulses when the quotient is ready.
// ---------------------------------------------------------------------------
module frsq_div
   import frsq_pkg::*;
#(
   parameter int DVD_W = 34,
   parameter int DVS_W = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] trial;

   // one restoring step
   always_comb begin
      shifted = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial[DVS_W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DVS_W:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/fair_share_run_queue_unit.sv -----
// ---------------------------------------------------------------------------
// fair_share_run_queue_unit: fair-share run queue ordered by virtual runtime
// Tasks sit in a sorted chain of cells; the head cell holds the minimum.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one request per transfer; req_tuser is the request kind
//            (insert, pop minimum, preemption query).
//   rsp_*  : exactly one result per request, in request order.
//   csr_*  : writes the preemption granularity (index 0) or the base period
//            (index 1); only while no request is in flight. Always ready.
// Work per request kind:
//   insert : the bit-serial divider charges vruntime, then the entry is
//            inserted into the chain.
//   pop    : the head leaves the chain, a multiply step, then the same
//            divider for the timeslice.
//   query, full, empty, unused kind : no multiply or divider work.
// One request is worked at a time; req_tready returns the cycle after the
// result is loaded. A finished result waits in the output register while
// the next request is accepted; if rsp_tready stays low, the next result
// holds the controller until the register drains.
// Reset empties the queue, zeroes the counters and restores granularity 40
// and period 320.
// ---------------------------------------------------------------------------
module fair_share_run_queue_unit
   import frsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1),
   localparam int OUT_W   = ((1 + TID_W + VT_W + TICK_W + CNT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // task_id[15:0], nice_level[21:16], virt_time[52:22], run_ticks[68:53],
   // slice_ticks[84:69], zero fill above
   input  logic [87:0]      req_tdata,
   // req_type[1:0]
   input  logic [1:0]       req_tuser,
   input  logic             req_tvalid,
   output logic             req_tready,
   // preempt[0], out_task_id[16:1], out_virt_time[47:17], out_slice[63:48],
   // queue_count[64+CNT_W-1:64], zero fill above
   output logic [OUT_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   input  logic             csr_valid,
   output logic             csr_ready
);

   localparam int WT_W  = $clog2(QUEUE_DEPTH * WEIGHT_MAX + 1);
   localparam int PER_W = (CNT_W + GRAN_W > LAT_W) ? CNT_W + GRAN_W : LAT_W;
   localparam int DVD_W = PER_W + WEIGHT_W;
   localparam int CHG_W = TICK_W + NICE_SHIFT;

   // request fields
   logic [TID_W-1:0]        in_tid;
   logic signed [NICE_W-1:0] in_nice;
   logic [VT_W-1:0]         in_vt;
   logic [TICK_W-1:0]       in_run, in_slice;
   req_type                 in_req;

   assign in_tid   = req_tdata[15:0];
   assign in_nice  = req_tdata[21:16];
   assign in_vt    = req_tdata[52:22];
   assign in_run   = req_tdata[68:53];
   assign in_slice = req_tdata[84:69];
   assign in_req   = req_type'(req_tuser);

   state_type st_ff, st_in;
   logic [GRAN_W-1:0]   gran_r_ff;
   logic [LAT_W-1:0]    lat_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [WT_W-1:0]     total_ff;
   logic [STAMP_W-1:0]  stamp_ff;
   logic [TID_W-1:0]    tid_ff;
   logic [VT_W-1:0]     vt_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic [PER_W-1:0]    per_ff;
   status_type          res_sts_ff;
   logic                res_pre_ff;
   logic [TID_W-1:0]    res_tid_ff;
   logic [VT_W-1:0]     res_vt_ff;
   logic [TICK_W-1:0]   res_slice_ff;
   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_data_ff;
   logic [1:0]          rsp_user_ff;

   logic req_xfer, full, empty, send_ok;
   logic div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_quo;
   logic [WT_W-1:0]  div_dvs;
   cell_op_type      chain_op;
   entry_type        new_ent;

   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign send_ok    = !rsp_valid_ff || rsp_tready;

   // nice to weight
   logic signed [NICE_W:0] nice_idx;
   logic [5:0]             nice_sel;
   logic [WEIGHT_W-1:0]    in_weight;
   always_comb begin
      nice_idx = {in_nice[NICE_W-1], in_nice} + (NICE_W+1)'(NICE_OFFSET);
      if (nice_idx < 0) begin
         nice_sel = '0;
      end else if (nice_idx > (NICE_W+1)'(NICE_LEVELS - 1)) begin
         nice_sel = 6'(NICE_LEVELS - 1);
      end else begin
         nice_sel = nice_idx[5:0];
      end
      in_weight = weight_of(nice_sel);
   end

   // chain of cells
   logic      cell_gt [QUEUE_DEPTH];
   logic      cell_v  [QUEUE_DEPTH];
   entry_type cell_e  [QUEUE_DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic      lv, lg, rv;
         entry_type le, re;
         if (gi == 0) begin : g_first
            assign lv = 1'b0;
            assign le = '0;
            assign lg = 1'b0;
         end else begin : g_mid
            assign lv = cell_v[gi-1];
            assign le = cell_e[gi-1];
            assign lg = cell_gt[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign re = '0;
         end else begin : g_inner
            assign rv = cell_v[gi+1];
            assign re = cell_e[gi+1];
         end
         frsq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (chain_op),
            .new_ent     (new_ent),
            .left_valid  (lv),
            .left_ent    (le),
            .left_gt     (lg),
            .right_valid (rv),
            .right_ent   (re),
            .gt          (cell_gt[gi]),
            .valid       (cell_v[gi]),
            .ent         (cell_e[gi])
         );
      end
   endgenerate

   // shared divider
   frsq_div #(.DVD_W(DVD_W), .DVS_W(WT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   // charged vruntime, saturating
   logic [VT_W:0] charged_sum;
   logic [VT_W-1:0] charged;
   assign charged_sum = {1'b0, vt_ff} + (VT_W+1)'(div_quo[CHG_W-1:0]);
   assign charged = charged_sum[VT_W] ? '1 : charged_sum[VT_W-1:0];

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (in_req == REQ_INSERT && !full) begin
                  st_in = ST_CHARGE;
               end else if (in_req == REQ_POP && !empty) begin
                  st_in = ST_MULT;
               end else begin
                  st_in = ST_SEND;
               end
            end
         end
         ST_CHARGE: if (div_done) st_in = ST_SEND;
         ST_MULT:   st_in = ST_SLICE;
         ST_SLICE:  if (div_done) st_in = ST_SEND;
         ST_SEND:   if (send_ok) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_start = 1'b0;
      div_dvd   = DVD_W'({in_run, NICE_SHIFT'(0)});
      div_dvs   = WT_W'(in_weight);
      chain_op  = CELL_HOLD;
      case (st_ff)
         ST_IDLE: begin
            if (req_xfer && in_req == REQ_INSERT && !full) begin
               div_start = 1'b1;
            end
            if (req_xfer && in_req == REQ_POP && !empty) begin
               chain_op = CELL_POP;
            end
         end
         ST_CHARGE: begin
            if (div_done) chain_op = CELL_INSERT;
         end
         ST_MULT: begin
            // period * weight goes straight into the divider
            div_start = 1'b1;
            div_dvd   = DVD_W'(per_ff) * DVD_W'(w_ff);
            div_dvs   = total_ff + WT_W'(w_ff);
         end
         default: ;
      endcase
   end

   assign new_ent = '{vtime: charged, stamp: stamp_ff, task_id: tid_ff, weight: w_ff};

   // preemption decision
   logic query_pre;
   always_comb begin
      if (in_run < TICK_W'(gran_r_ff) && in_run != '0) begin
         query_pre = 1'b0;
      end else if (in_run >= in_slice) begin
         query_pre = 1'b1;
      end else begin
         query_pre = cell_v[0] && (in_vt > cell_e[0].vtime);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         gran_r_ff    <= GRAN_W'(GRAN_RESET);
         lat_ff       <= LAT_W'(LAT_RESET);
         count_ff     <= '0;
         total_ff     <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == 2'(CSR_GRAN)) gran_r_ff <= csr_data[GRAN_W-1:0];
            if (csr_index == 2'(CSR_LAT))  lat_ff    <= csr_data[LAT_W-1:0];
         end
         if (chain_op == CELL_POP) begin
            count_ff <= count_ff - 1'b1;
            total_ff <= total_ff - WT_W'(cell_e[0].weight);
         end else if (chain_op == CELL_INSERT) begin
            count_ff <= count_ff + 1'b1;
            total_ff <= total_ff + WT_W'(w_ff);
            stamp_ff <= stamp_ff + 1'b1;
         end
         if (st_ff == ST_SEND && send_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and result registers
   logic [CNT_W+GRAN_W-1:0] per_prod;
   assign per_prod = (count_ff - 1'b1) * gran_r_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tid_ff       <= in_tid;
         vt_ff        <= in_vt;
         w_ff         <= (in_req == REQ_POP) ? cell_e[0].weight : in_weight;
         per_ff       <= (PER_W'(per_prod) > PER_W'(lat_ff)) ?
                         PER_W'(per_prod) : PER_W'(lat_ff);
         res_sts_ff   <= STS_OK;
         res_pre_ff   <= 1'b0;
         res_tid_ff   <= '0;
         res_vt_ff    <= '0;
         res_slice_ff <= '0;
         case (in_req)
            REQ_INSERT: if (full) res_sts_ff <= STS_FULL;
            REQ_POP: begin
               if (empty) begin
                  res_sts_ff <= STS_EMPTY;
               end else begin
                  res_tid_ff <= cell_e[0].task_id;
                  res_vt_ff  <= cell_e[0].vtime;
               end
            end
            REQ_QUERY: res_pre_ff <= query_pre;
            default: ;
         endcase
      end
      if (st_ff == ST_CHARGE && div_done) begin
         res_tid_ff <= tid_ff;
         res_vt_ff  <= charged;
      end
      if (st_ff == ST_SLICE && div_done) begin
         res_slice_ff <= (div_quo > DVD_W'({TICK_W{1'b1}})) ? '1 : div_quo[TICK_W-1:0];
      end
      if (st_ff == ST_SEND && send_ok) begin
         rsp_data_ff <= OUT_W'({count_ff, res_slice_ff, res_vt_ff, res_tid_ff, res_pre_ff});
         rsp_user_ff <= res_sts_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- hdl/frsq_checker.sv -----
// ---------------------------------------------------------------------------
// frsq_checker: port-level checks for the fair-share run queue
// Watches the result channel and the request handshake.
// ---------------------------------------------------------------------------
module frsq_checker
   import frsq_pkg::*;
#(
   parameter int OUT_W = 72
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic [1:0]       rsp_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an empty pop reports nothing held and no task
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_EMPTY |->
         rsp_tdata[OUT_W-1:64] == '0 && rsp_tdata[47:1] == '0)
      else $error("empty pop carries data");

   // a full insert carries no task, vruntime, slice or preempt bit
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_FULL |-> rsp_tdata[63:0] == '0)
      else $error("full insert carries data");

   // no request taken the cycle after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

endmodule

bind fair_share_run_queue_unit frsq_checker #(.OUT_W(OUT_W)) u_frsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
